/* sv/ctk_pkg.sv */
package ctk_pkg;

    // Default sizes of the stores.
    localparam int DOC_MAX_DEF = 4096;
    localparam int DIM_MAX_DEF = 256;
    localparam int K_MAX_DEF   = 16;

    // Fixed datapath widths.
    localparam int ELEM_W = 16;
    localparam int ID_W   = 32;
    localparam int LEN_W  = 9;
    localparam int BC_W   = 5;
    localparam int SUM_W  = 40;
    localparam int ROOT_W = 20;
    localparam int ACC_W  = 40;
    localparam int NUM_W  = 41;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int RANK_W = 4;

    // Configuration register indexes.
    localparam logic CFG_VECTOR_LENGTH = 1'b0;
    localparam logic CFG_BEST_COUNT    = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ADDED = 3'd0,
        ST_MATCH = 3'd1,
        ST_NODOC = 3'd2,
        ST_LEN   = 3'd3,
        ST_ZERO  = 3'd4,
        ST_FULL  = 3'd5
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE, S_STAT, S_SQRT, S_N_RD, S_N_GO, S_N_DIV, S_ADD_END,
        S_Q_DOC, S_Q_DOT, S_Q_DIV, S_Q_INS, S_OUT
    } t_state;

    // True when entry a ranks before entry b: higher score, then lower id.
    function automatic logic ranks_before(input logic signed [ELEM_W-1:0] sa,
                                          input logic [ID_W-1:0] ia,
                                          input logic signed [ELEM_W-1:0] sb,
                                          input logic [ID_W-1:0] ib);
        ranks_before = (sa > sb) || ((sa == sb) && (ia < ib));
    endfunction

endpackage

/* sv/ctk_ram.sv */
module ctk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/ctk_div.sv */
module ctk_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ctk_pkg::NUM_W-1:0] i_num,
    input  logic [ctk_pkg::DEN_W-1:0] i_den,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [ctk_pkg::NUM_W-1:0] o_quo
);
    import ctk_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_trial;
    logic             n_fit;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        n_trial = {r_rem, r_num[NUM_W-1]};
        n_fit   = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= n_fit ? DEN_W'(n_trial - {1'b0, r_den}) : DEN_W'(n_trial);
                r_quo <= {r_quo[NUM_W-2:0], n_fit};
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* sv/cosine_top_k_vector_search.sv */
// Brute-force cosine search. Vector elements stream in one beat per cycle;
// the beat that closes a vector holds the input until its work is done.
// A closing add beat runs the integer square root, then passes each of the
// vector_length elements through the one shared bit-serial divider, writes
// zero for each padding element up to DIM_MAX, then records the id and
// issues the result. A closing query beat runs the square root, then for
// every stored document a streaming dot product on the memory read port
// and one division, then issues the result beats. Error results pass
// through the status state to the output register. Documents are kept in a
// single synchronous memory of DOC_MAX * DIM_MAX elements, zero-padded to
// DIM_MAX.
module cosine_top_k_vector_search #(
    parameter int DOC_MAX = ctk_pkg::DOC_MAX_DEF,
    parameter int DIM_MAX = ctk_pkg::DIM_MAX_DEF,
    parameter int K_MAX   = ctk_pkg::K_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    // Element beats in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // doc_id[31:0], element[47:32]
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,   // last
    // Result beats out.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // match_id[31:0], score[47:32], rank[51:48], zero
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast    // final_res
);
    import ctk_pkg::*;

    localparam int DIM_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int DOC_W = (DOC_MAX > 1) ? $clog2(DOC_MAX) : 1;
    localparam int VA_W  = (DOC_MAX * DIM_MAX > 1) ? $clog2(DOC_MAX * DIM_MAX) : 1;
    localparam int CNT_W = $clog2(DOC_MAX + 1);
    localparam int JW    = $clog2(DIM_MAX + 1);
    localparam int KI_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int KN_W  = $clog2(K_MAX + 1);
    localparam int SQ_CW = $clog2(ROOT_W + 1);

    t_state r_state, n_state;

    logic [LEN_W-1:0] r_vec_len;
    logic [BC_W-1:0]  r_best_cnt;
    logic [LEN_W-1:0] r_elem_cnt;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic [VA_W-1:0]  r_add_base;
    logic [VA_W-1:0]  r_q_base;
    logic [DOC_W-1:0] r_doc;
    logic [JW-1:0]    r_j;
    logic [JW-1:0]    r_len;
    logic [KN_W-1:0]  r_k;
    logic [KN_W-1:0]  r_n;
    logic [KI_W-1:0]  r_oi;
    logic             r_is_query;
    logic [ID_W-1:0]  r_id;
    t_status          r_stat;

    logic [SUM_W-1:0]  r_sq_val;
    logic [ROOT_W+1:0] r_sq_rem;
    logic [ROOT_W-1:0] r_sq_root;
    logic [SQ_CW-1:0]  r_sq_cnt;

    logic                     r_v1, r_v2, r_x_neg;
    logic signed [31:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ELEM_W-1:0] r_sc;

    logic signed [ELEM_W-1:0] r_bl_sc [K_MAX];
    logic [ID_W-1:0]          r_bl_id [K_MAX];
    logic signed [ELEM_W-1:0] n_bl_sc [K_MAX];
    logic [ID_W-1:0]          n_bl_id [K_MAX];
    logic [K_MAX-1:0]         n_beat;

    logic             r_o_valid;
    t_status          r_o_stat;
    logic [ID_W-1:0]  r_o_id;
    logic [ELEM_W-1:0] r_o_sc;
    logic [RANK_W-1:0] r_o_rank;
    logic             r_o_last;

    // Memory ports.
    logic                     pend_wr, pend_rd;
    logic [DIM_W-1:0]         pend_wr_addr;
    logic signed [ELEM_W-1:0] pend_dout, store_dout;
    logic                     store_wr, store_rd;
    logic [VA_W-1:0]          store_addr;
    logic [ELEM_W-1:0]        store_din;
    logic                     id_wr, id_rd;
    logic [ID_W-1:0]          id_dout;

    logic                     div_start, div_busy, div_done;
    logic [NUM_W-1:0]         div_num, div_quo;
    logic [DEN_W-1:0]         div_den;

    logic                     s_acc, out_free, out_load;
    logic signed [ELEM_W-1:0] in_elem;
    logic [LEN_W-1:0]         new_cnt;
    logic [SUM_W-1:0]         new_sum;
    logic                     len_bad, is_zero;
    logic [31:0]              k_tmp;
    logic [KN_W-1:0]          close_k;
    t_status                  close_stat;
    logic                     close_err, close_go;
    logic                     dot_done;
    logic [ROOT_W+3:0]        sq_cand, sq_sub;
    logic signed [ELEM_W-1:0] clamp_v;
    logic [ELEM_W-1:0]        pend_mag;
    logic [ACC_W-1:0]         acc_mag;

    assign o_cfg_ready = 1'b1;
    assign s_acc       = s_tvalid && s_tready;
    assign out_free    = !r_o_valid || m_tready;
    assign in_elem     = s_tdata[47:32];

    // Figures for the closing beat: final count and sum, checks, match count.
    always_comb begin
        new_cnt = (r_elem_cnt != '1) ? r_elem_cnt + 1'b1 : r_elem_cnt;
        new_sum = r_sum + SUM_W'(unsigned'(32'(in_elem * in_elem)));
        len_bad = (new_cnt != r_vec_len) || (r_vec_len == '0) || (32'(r_vec_len) > DIM_MAX);
        is_zero = (new_sum == '0);
        k_tmp   = (32'(r_best_cnt) > K_MAX) ? 32'(K_MAX) : 32'(r_best_cnt);
        if (32'(r_count) < k_tmp) begin
            k_tmp = 32'(r_count);
        end
        close_k    = KN_W'(k_tmp);
        close_err  = 1'b1;
        close_go   = 1'b0;
        close_stat = ST_ADDED;
        if (s_tuser) begin
            if (r_count == '0) begin
                close_stat = ST_NODOC;
            end else if (len_bad) begin
                close_stat = ST_LEN;
            end else if (is_zero) begin
                close_stat = ST_ZERO;
            end else begin
                close_err = 1'b0;
                close_go  = (close_k != '0);
            end
        end else begin
            if (len_bad) begin
                close_stat = ST_LEN;
            end else if (is_zero) begin
                close_stat = ST_ZERO;
            end else if (32'(r_count) >= DOC_MAX) begin
                close_stat = ST_FULL;
            end else begin
                close_err = 1'b0;
                close_go  = 1'b1;
            end
        end
    end

    // Square root step: two radicand bits in, one root bit out.
    always_comb begin
        sq_cand = {r_sq_rem, r_sq_val[SUM_W-1 -: 2]};
        sq_sub  = (ROOT_W + 4)'({r_sq_root, 2'b01});
    end

    // Divider operands and result rounding back to Q1.15.
    always_comb begin
        pend_mag = pend_dout[ELEM_W-1] ? ELEM_W'(-pend_dout) : ELEM_W'(pend_dout);
        acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        div_den  = {r_sq_root, 1'b0};
        if (r_state == S_N_GO) begin
            div_num = NUM_W'({pend_mag, 16'b0}) + NUM_W'(r_sq_root);
        end else begin
            div_num = NUM_W'({acc_mag, 1'b0}) + NUM_W'(r_sq_root);
        end
        if (r_x_neg) begin
            clamp_v = (div_quo > NUM_W'(32768)) ? -16'sd32768 : ELEM_W'(17'd0 - div_quo[16:0]);
        end else begin
            clamp_v = (div_quo > NUM_W'(32767)) ? 16'sd32767 : ELEM_W'(div_quo[15:0]);
        end
    end

    assign dot_done = (r_j == r_len) && !r_v1 && !r_v2;

    // Insertion into the sorted best list.
    always_comb begin
        for (int p = 0; p < K_MAX; p++) begin
            n_beat[p] = (p >= 32'(r_n)) ||
                        ranks_before(r_sc, id_dout, r_bl_sc[p], r_bl_id[p]);
        end
        for (int p = 0; p < K_MAX; p++) begin
            n_bl_sc[p] = r_bl_sc[p];
            n_bl_id[p] = r_bl_id[p];
            if ((p < 32'(r_k)) && n_beat[p]) begin
                if (p == 0) begin
                    n_bl_sc[p] = r_sc;
                    n_bl_id[p] = id_dout;
                end else if (!n_beat[p-1]) begin
                    n_bl_sc[p] = r_sc;
                    n_bl_id[p] = id_dout;
                end else begin
                    n_bl_sc[p] = r_bl_sc[p-1];
                    n_bl_id[p] = r_bl_id[p-1];
                end
            end
        end
    end

    // Sequencer: next state and memory strobes.
    always_comb begin
        n_state      = r_state;
        s_tready     = (r_state == S_IDLE);
        pend_wr      = 1'b0;
        pend_rd      = 1'b0;
        store_wr     = 1'b0;
        store_rd     = 1'b0;
        id_wr        = 1'b0;
        id_rd        = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        pend_wr_addr = DIM_W'(r_elem_cnt);
        store_addr   = (r_is_query ? r_q_base : r_add_base) + VA_W'(r_j);
        store_din    = (r_state == S_N_DIV) ? clamp_v : '0;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    pend_wr = (32'(r_elem_cnt) < DIM_MAX);
                    if (s_tlast) begin
                        if (close_err) begin
                            n_state = S_STAT;
                        end else if (close_go) begin
                            n_state = S_SQRT;
                        end
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SQRT: begin
                if (r_sq_cnt == SQ_CW'(1)) begin
                    n_state = r_is_query ? S_Q_DOC : S_N_RD;
                end
            end
            S_N_RD: begin
                if (r_j < r_len) begin
                    pend_rd = 1'b1;
                    n_state = S_N_GO;
                end else begin
                    store_wr = 1'b1;
                    if (32'(r_j) == DIM_MAX - 1) begin
                        n_state = S_ADD_END;
                    end
                end
            end
            S_N_GO: begin
                div_start = 1'b1;
                n_state   = S_N_DIV;
            end
            S_N_DIV: begin
                if (div_done) begin
                    store_wr = 1'b1;
                    n_state  = (32'(r_j) == DIM_MAX - 1) ? S_ADD_END : S_N_RD;
                end
            end
            S_ADD_END: begin
                id_wr   = 1'b1;
                n_state = S_STAT;
            end
            S_Q_DOC: begin
                id_rd   = 1'b1;
                n_state = S_Q_DOT;
            end
            S_Q_DOT: begin
                if (r_j < r_len) begin
                    pend_rd  = 1'b1;
                    store_rd = 1'b1;
                end
                if (dot_done) begin
                    div_start = 1'b1;
                    n_state   = S_Q_DIV;
                end
            end
            S_Q_DIV: begin
                if (div_done) begin
                    n_state = S_Q_INS;
                end
            end
            S_Q_INS: begin
                n_state = (32'(r_doc) + 1 == 32'(r_count)) ? S_OUT : S_Q_DOC;
            end
            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (32'(r_oi) + 1 == 32'(r_n)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len  <= LEN_W'(128);
            r_best_cnt <= BC_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VECTOR_LENGTH: r_vec_len  <= i_cfg_data;
                CFG_BEST_COUNT:    r_best_cnt <= i_cfg_data[BC_W-1:0];
                default:           r_vec_len  <= r_vec_len;
            endcase
        end
    end

    // Datapath and bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_cnt <= '0;
            r_sum      <= '0;
            r_count    <= '0;
            r_add_base <= '0;
            r_n        <= '0;
            r_k        <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (s_tlast) begin
                            r_elem_cnt <= '0;
                            r_sum      <= '0;
                            r_sq_val   <= new_sum;
                            r_sq_rem   <= '0;
                            r_sq_root  <= '0;
                            r_sq_cnt   <= SQ_CW'(ROOT_W);
                            r_is_query <= s_tuser;
                            r_id       <= s_tdata[31:0];
                            r_len      <= JW'(r_vec_len);
                            r_k        <= close_k;
                            r_n        <= '0;
                            r_oi       <= '0;
                            r_stat     <= close_stat;
                            r_j        <= '0;
                            r_doc      <= '0;
                            r_q_base   <= '0;
                        end else begin
                            r_elem_cnt <= new_cnt;
                            r_sum      <= new_sum;
                        end
                    end
                end
                S_SQRT: begin
                    r_sq_val <= {r_sq_val[SUM_W-3:0], 2'b00};
                    r_sq_cnt <= r_sq_cnt - 1'b1;
                    if (sq_cand >= sq_sub) begin
                        r_sq_rem  <= (ROOT_W + 2)'(sq_cand - sq_sub);
                        r_sq_root <= {r_sq_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_sq_rem  <= (ROOT_W + 2)'(sq_cand);
                        r_sq_root <= {r_sq_root[ROOT_W-2:0], 1'b0};
                    end
                end
                S_N_RD: begin
                    if (r_j >= r_len) begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_N_GO: begin
                    r_x_neg <= pend_dout[ELEM_W-1];
                end
                S_N_DIV: begin
                    if (div_done) begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_ADD_END: begin
                    r_count    <= r_count + 1'b1;
                    r_add_base <= r_add_base + VA_W'(DIM_MAX);
                    r_stat     <= ST_ADDED;
                end
                S_Q_DOC: begin
                    r_j   <= '0;
                    r_acc <= '0;
                    r_v1  <= 1'b0;
                    r_v2  <= 1'b0;
                end
                S_Q_DOT: begin
                    r_v1   <= (r_j < r_len);
                    r_v2   <= r_v1;
                    r_prod <= pend_dout * store_dout;
                    if (r_j < r_len) begin
                        r_j <= r_j + 1'b1;
                    end
                    if (r_v2) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    if (dot_done) begin
                        r_x_neg <= r_acc[ACC_W-1];
                    end
                end
                S_Q_DIV: begin
                    if (div_done) begin
                        r_sc <= clamp_v;
                    end
                end
                S_Q_INS: begin
                    r_bl_sc  <= n_bl_sc;
                    r_bl_id  <= n_bl_id;
                    r_n      <= (r_n < r_k) ? r_n + 1'b1 : r_n;
                    r_doc    <= r_doc + 1'b1;
                    r_q_base <= r_q_base + VA_W'(DIM_MAX);
                end
                S_OUT: begin
                    if (out_free) begin
                        r_oi <= r_oi + 1'b1;
                    end
                end
                default: r_j <= r_j;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
            if (r_state == S_OUT) begin
                r_o_stat <= ST_MATCH;
                r_o_id   <= r_bl_id[r_oi];
                r_o_sc   <= r_bl_sc[r_oi];
                r_o_rank <= RANK_W'(r_oi);
                r_o_last <= (32'(r_oi) + 1 == 32'(r_n));
            end else begin
                r_o_stat <= r_stat;
                r_o_id   <= '0;
                r_o_sc   <= '0;
                r_o_rank <= '0;
                r_o_last <= 1'b1;
            end
        end else if (m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign m_tvalid = r_o_valid;
    assign m_tdata  = {4'b0, r_o_rank, r_o_sc, r_o_id};
    assign m_tuser  = r_o_stat;
    assign m_tlast  = r_o_last;

    // Elements of the vector being received.
    ctk_ram #(.WIDTH(ELEM_W), .DEPTH(DIM_MAX)) u_pend_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pend_wr),
        .i_wr_addr (pend_wr_addr),
        .i_wr_data (in_elem),
        .i_rd_en   (pend_rd),
        .i_rd_addr (DIM_W'(r_j)),
        .o_rd_data (pend_dout)
    );

    // Normalised document vectors.
    ctk_ram #(.WIDTH(ELEM_W), .DEPTH(DOC_MAX * DIM_MAX)) u_store_ram (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr),
        .i_wr_addr (store_addr),
        .i_wr_data (store_din),
        .i_rd_en   (store_rd),
        .i_rd_addr (store_addr),
        .o_rd_data (store_dout)
    );

    // Document identifiers.
    ctk_ram #(.WIDTH(ID_W), .DEPTH(DOC_MAX)) u_id_ram (
        .i_clk     (i_clk),
        .i_wr_en   (id_wr),
        .i_wr_addr (DOC_W'(r_count)),
        .i_wr_data (r_id),
        .i_rd_en   (id_rd),
        .i_rd_addr (r_doc),
        .o_rd_data (id_dout)
    );

    ctk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // The best list never holds more entries than the query asked for.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_n <= r_k)
        else $error("best list overfilled");

    // The store never grows past its capacity.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) 32'(r_count) <= DOC_MAX)
        else $error("document count beyond capacity");

    // The divider is only started when idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // A new result beat is only loaded when the output stage can take it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("output overwritten while stalled");

endmodule
